// ----- hw/rtl/avtm_pkg.sv -----
// Package with the widths, register map and entry type of the timestamp reorder queue.
package avtm_pkg;

   localparam int TIME_W = 32;
   localparam int TAG_W = 16;
   localparam int THR_W = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   localparam logic [THR_W-1:0] PURE_THRESHOLD_RESET = 7'd10;

   localparam logic [CSR_ADDR_W-1:0] CSR_PURE_THRESHOLD_ADDR = 2'd0;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0] timestamp;
      logic              video_kind;
      logic [TAG_W-1:0]  tag;
   } entry_type;

endpackage

// ----- hw/rtl/avtm_req_if.sv -----
// Request channel interface carrying one packet word or a clear command.
interface avtm_req_if;
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [avtm_pkg::TIME_W-1:0]  timestamp;
   logic                         video_kind;
   logic [avtm_pkg::TAG_W-1:0]   packet_tag;

   modport source (output valid, output op, output timestamp, output video_kind,
                   output packet_tag, input ready);
   modport sink (input valid, input op, input timestamp, input video_kind,
                 input packet_tag, output ready);
endinterface

// ----- hw/rtl/avtm_rsp_if.sv -----
// Response channel interface carrying one released packet word.
interface avtm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [avtm_pkg::TIME_W-1:0]  out_timestamp;
   logic                         out_video_kind;
   logic [avtm_pkg::TAG_W-1:0]   out_tag;
   logic                         forced;

   modport source (output valid, output out_timestamp, output out_video_kind,
                   output out_tag, output forced, input ready);
   modport sink (input valid, input out_timestamp, input out_video_kind,
                 input out_tag, input forced, output ready);
endinterface

// ----- hw/rtl/av_timestamp_mix_reorder_queue_core.sv -----
// Top level of the timestamp-ordered audio and video reorder queue.
//
//  Channel   Direction  Handshake            Word
//  req_if    in         valid/ready          op, timestamp, video_kind, packet_tag
//  rsp_if    out        valid/ready          out_timestamp, out_video_kind, out_tag, forced
//  csr_*     in         APB write/read       pure_threshold at byte address 0
//
// A clear completes in its accepting cycle. A push takes its accepting cycle, an insertion
// walk (a direct write into an empty queue, else a start step and compare steps that move
// each later entry up one place) and a release check; a release adds a head read and the
// hand-off, all paced by the single memory port pair. A full-queue push does a head compare
// and hand-off before the walk and skips the check; a new word below the head is not stored.
// Reset empties the queue and sets the threshold to ten; a stalled response holds the block.
module av_timestamp_mix_reorder_queue_core #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   avtm_req_if.sink                          req_if,
   avtm_rsp_if.source                        rsp_if,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [avtm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [avtm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [avtm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int CMPW = (CW > avtm_pkg::THR_W) ? CW : avtm_pkg::THR_W;
   localparam logic [AW:0] DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
   localparam logic [AW-1:0] LAST_POS = AW'(QUEUE_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK_START,
      ST_WALK_CMP,
      ST_FULL_CMP,
      ST_CHECK,
      ST_HEAD_WAIT,
      ST_EMIT
   } state_type;

   avtm_pkg::entry_type mem [QUEUE_DEPTH];
   avtm_pkg::entry_type rd_data_ff;
   logic [AW-1:0]       rd_addr;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   avtm_pkg::entry_type mem_wdata;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   logic                          full_mode_ff, full_mode_in;
   logic [AW-1:0]                 pos_ff, pos_in;
   logic [AW-1:0]                 head_ff, head_in;
   logic [CW-1:0]                 video_ff, video_in;
   logic [CW-1:0]                 audio_ff, audio_in;
   logic [avtm_pkg::THR_W-1:0]    thr_ff, thr_in;
   avtm_pkg::entry_type           new_ff, new_in;
   avtm_pkg::entry_type           out_ff, out_in;
   logic                          out_forced_ff, out_forced_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   avtm_pkg::entry_type           rsp_entry_ff, rsp_entry_in;
   logic                          rsp_forced_ff, rsp_forced_in;

   logic [CW-1:0]   used;
   logic            cmp_gt;
   logic            release_ok;
   logic [CMPW-1:0] video_x, audio_x, thr_x;
   logic            req_take;
   logic            csr_write;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] l);
      logic [AW:0] s;
      s = {1'b0, h} + {1'b0, l};
      if (s >= DEPTH_W) begin
         s = s - DEPTH_W;
      end
      return s[AW-1:0];
   endfunction

   assign used = video_ff + audio_ff;
   assign cmp_gt = rd_data_ff.timestamp > new_ff.timestamp;
   assign video_x = CMPW'(video_ff);
   assign audio_x = CMPW'(audio_ff);
   assign thr_x = CMPW'(thr_ff);
   assign release_ok = ((video_x >= thr_x) && (audio_ff == '0)) ||
                       ((audio_x >= thr_x) && (video_ff == '0)) ||
                       ((video_ff != '0) && (audio_ff != '0));

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take = req_if.valid && req_if.ready;

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.out_timestamp = rsp_entry_ff.timestamp;
   assign rsp_if.out_video_kind = rsp_entry_ff.video_kind;
   assign rsp_if.out_tag = rsp_entry_ff.tag;
   assign rsp_if.forced = rsp_forced_ff;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr == avtm_pkg::CSR_PURE_THRESHOLD_ADDR) ?
                       avtm_pkg::CSR_DATA_W'(thr_ff) : '0;

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      full_mode_in = full_mode_ff;
      pos_in = pos_ff;
      head_in = head_ff;
      video_in = video_ff;
      audio_in = audio_ff;
      thr_in = thr_ff;
      new_in = new_ff;
      out_in = out_ff;
      out_forced_in = out_forced_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_forced_in = rsp_forced_ff;
      mem_we = 1'b0;
      mem_waddr = phys(head_ff, pos_ff);
      mem_wdata = new_ff;
      rd_addr = phys(head_ff, pos_ff - AW'(1));

      if (csr_write && (csr_paddr == avtm_pkg::CSR_PURE_THRESHOLD_ADDR)) begin
         thr_in = csr_pwdata[avtm_pkg::THR_W-1:0];
      end
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_if.op == avtm_pkg::OP_CLEAR) begin
                  video_in = '0;
                  audio_in = '0;
               end else begin
                  new_in.timestamp = req_if.timestamp;
                  new_in.video_kind = req_if.video_kind;
                  new_in.tag = req_if.packet_tag;
                  if (used == DEPTH_C) begin
                     rd_addr = head_ff;
                     full_mode_in = 1'b1;
                     state_in = ST_FULL_CMP;
                  end else begin
                     pos_in = used[AW-1:0];
                     full_mode_in = 1'b0;
                     state_in = ST_WALK_START;
                  end
               end
            end
         end
         ST_WALK_START: begin
            if (pos_ff == '0) begin
               mem_we = 1'b1;
               if (new_ff.video_kind) begin
                  video_in = video_ff + CW'(1);
               end else begin
                  audio_in = audio_ff + CW'(1);
               end
               state_in = full_mode_ff ? ST_IDLE : ST_CHECK;
            end else begin
               state_in = ST_WALK_CMP;
            end
         end
         ST_WALK_CMP: begin
            rd_addr = phys(head_ff, pos_ff - AW'(2));
            mem_we = 1'b1;
            if (cmp_gt) begin
               mem_wdata = rd_data_ff;
               pos_in = pos_ff - AW'(1);
               if (pos_ff == AW'(1)) begin
                  state_in = ST_WALK_START;
               end
            end else begin
               if (new_ff.video_kind) begin
                  video_in = video_ff + CW'(1);
               end else begin
                  audio_in = audio_ff + CW'(1);
               end
               state_in = full_mode_ff ? ST_IDLE : ST_CHECK;
            end
         end
         ST_FULL_CMP: begin
            out_forced_in = 1'b1;
            ret_in = ST_IDLE;
            state_in = ST_EMIT;
            if (cmp_gt) begin
               out_in = new_ff;
            end else begin
               out_in = rd_data_ff;
               if (rd_data_ff.video_kind) begin
                  video_in = video_ff - CW'(1);
               end else begin
                  audio_in = audio_ff - CW'(1);
               end
               head_in = phys(head_ff, AW'(1));
               pos_in = LAST_POS;
               ret_in = ST_WALK_START;
            end
         end
         ST_CHECK: begin
            rd_addr = head_ff;
            state_in = release_ok ? ST_HEAD_WAIT : ST_IDLE;
         end
         ST_HEAD_WAIT: begin
            out_in = rd_data_ff;
            out_forced_in = 1'b0;
            if (rd_data_ff.video_kind) begin
               video_in = video_ff - CW'(1);
            end else begin
               audio_in = audio_ff - CW'(1);
            end
            head_in = phys(head_ff, AW'(1));
            ret_in = ST_IDLE;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = out_ff;
               rsp_forced_in = out_forced_ff;
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         full_mode_ff <= 1'b0;
         pos_ff <= '0;
         head_ff <= '0;
         video_ff <= '0;
         audio_ff <= '0;
         thr_ff <= avtm_pkg::PURE_THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         full_mode_ff <= full_mode_in;
         pos_ff <= pos_in;
         head_ff <= head_in;
         video_ff <= video_in;
         audio_ff <= audio_in;
         thr_ff <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      new_ff <= new_in;
      out_ff <= out_in;
      out_forced_ff <= out_forced_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_forced_ff <= rsp_forced_in;
   end

`ifndef NO_ASSERTIONS
   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, video_ff} + {1'b0, audio_ff}) <= (CW + 1)'(QUEUE_DEPTH))
      else $error("queue occupancy exceeds its depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_if.op == avtm_pkg::OP_CLEAR)) |=>
      (video_ff == '0) && (audio_ff == '0))
      else $error("clear did not empty the queue");

   a_walk_position: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_CMP) |-> (pos_ff != '0))
      else $error("insertion walk compared below the head");

   a_response_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside the hand-off state");
`endif

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the timestamp-ordered audio and video reorder queue.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;
   localparam int SETTLE_CYCLES = DEPTH + 24;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [avtm_pkg::TIME_W-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic                        op;
      logic [avtm_pkg::TIME_W-1:0] timestamp;
      logic                        video_kind;
      logic [avtm_pkg::TAG_W-1:0]  tag;
   } packet_type;

   typedef struct packed {
      logic [avtm_pkg::TIME_W-1:0] timestamp;
      logic                        video_kind;
      logic [avtm_pkg::TAG_W-1:0]  tag;
      logic                        forced;
   } release_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [avtm_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [avtm_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [avtm_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   avtm_req_if req_if ();
   avtm_rsp_if rsp_if ();

   av_timestamp_mix_reorder_queue_core #(.QUEUE_DEPTH(DEPTH)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   packet_type                 send_q[$];
   release_type                release_due[$];
   avtm_pkg::entry_type        sorted_store[$];
   int unsigned                video_held = 0;
   int unsigned                audio_held = 0;
   logic [avtm_pkg::THR_W-1:0] threshold_copy = avtm_pkg::PURE_THRESHOLD_RESET;
   int unsigned                words_queued = 0;
   int unsigned                words_taken = 0;
   int unsigned                mismatches = 0;
   int unsigned                quiet_cycles = 0;
   int unsigned                send_gap = 0;
   int unsigned                sink_stall = 0;
   bit                         burst_mode = 1'b0;
   logic                       req_taken = 1'b0;
   logic [avtm_pkg::TIME_W-1:0] ts_base = '0;
   logic [avtm_pkg::TIME_W-1:0] ts_last = '0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 55) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(25, 80);
   endfunction

   task automatic take_head(input logic forced_flag);
      avtm_pkg::entry_type head;
      release_type         due;
      head = sorted_store.pop_front();
      if (head.video_kind) begin
         video_held--;
      end else begin
         audio_held--;
      end
      due.timestamp = head.timestamp;
      due.video_kind = head.video_kind;
      due.tag = head.tag;
      due.forced = forced_flag;
      release_due.push_back(due);
   endtask

   // Updates the shadow queue for one accepted word and records the release it causes.
   task automatic predict_release(input packet_type w);
      avtm_pkg::entry_type fresh;
      release_type         due;
      int                  pos;
      int                  i;
      bit                  full_path;
      bit                  release_now;
      if (w.op == avtm_pkg::OP_CLEAR) begin
         sorted_store.delete();
         video_held = 0;
         audio_held = 0;
         return;
      end
      full_path = sorted_store.size() >= DEPTH;
      if (full_path && w.timestamp < sorted_store[0].timestamp) begin
         due.timestamp = w.timestamp;
         due.video_kind = w.video_kind;
         due.tag = w.tag;
         due.forced = 1'b1;
         release_due.push_back(due);
         return;
      end
      if (full_path) begin
         take_head(1'b1);
      end
      fresh.timestamp = w.timestamp;
      fresh.video_kind = w.video_kind;
      fresh.tag = w.tag;
      pos = sorted_store.size();
      for (i = 0; i < sorted_store.size(); i++) begin
         if (sorted_store[i].timestamp > w.timestamp) begin
            pos = i;
            break;
         end
      end
      sorted_store.insert(pos, fresh);
      if (w.video_kind) begin
         video_held++;
      end else begin
         audio_held++;
      end
      if (!full_path) begin
         release_now = (video_held >= threshold_copy && audio_held == 0) ||
                       (audio_held >= threshold_copy && video_held == 0) ||
                       (video_held >= 1 && audio_held >= 1);
         if (release_now) begin
            take_head(1'b0);
         end
      end
   endtask

   always @(negedge clock) begin
      packet_type next_word;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (send_gap > 0 || send_q.size() == 0) begin
            if (send_gap > 0) begin
               send_gap--;
            end
            req_if.valid <= 1'b0;
         end else begin
            next_word = send_q.pop_front();
            req_if.op <= next_word.op;
            req_if.timestamp <= next_word.timestamp;
            req_if.video_kind <= next_word.video_kind;
            req_if.packet_tag <= next_word.tag;
            req_if.valid <= 1'b1;
            send_gap = pick_gap();
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (sink_stall > 0) begin
         sink_stall--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if ($urandom_range(0, 99) < 30) begin
            sink_stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      packet_type  seen_word;
      release_type got;
      release_type want;
      if (reset) begin
         req_taken <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            seen_word.op = req_if.op;
            seen_word.timestamp = req_if.timestamp;
            seen_word.video_kind = req_if.video_kind;
            seen_word.tag = req_if.packet_tag;
            words_taken++;
            predict_release(seen_word);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.timestamp = rsp_if.out_timestamp;
            got.video_kind = rsp_if.out_video_kind;
            got.tag = rsp_if.out_tag;
            got.forced = rsp_if.forced;
            if (release_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected word: ts=%h video=%b tag=%h forced=%b",
                           got.timestamp, got.video_kind, got.tag, got.forced);
               end
            end else begin
               want = release_due.pop_front();
               if (got.timestamp !== want.timestamp || got.video_kind !== want.video_kind ||
                   got.tag !== want.tag || got.forced !== want.forced) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("word mismatch: expected ts=%h video=%b tag=%h forced=%b",
                              want.timestamp, want.video_kind, want.tag, want.forced);
                     $display("               actual   ts=%h video=%b tag=%h forced=%b",
                              got.timestamp, got.video_kind, got.tag, got.forced);
                  end
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_psel) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[av_timestamp_mix_reorder_queue_core] ERROR");
            $finish;
         end
      end
   end

   task automatic queue_push(input logic [avtm_pkg::TIME_W-1:0] t, input logic vid,
                             input logic [avtm_pkg::TAG_W-1:0] tag);
      packet_type w;
      w.op = avtm_pkg::OP_PUSH;
      w.timestamp = t;
      w.video_kind = vid;
      w.tag = tag;
      send_q.push_back(w);
      words_queued++;
   endtask

   task automatic queue_clear();
      packet_type w;
      w.op = avtm_pkg::OP_CLEAR;
      w.timestamp = $urandom();
      w.video_kind = $urandom_range(0, 1);
      w.tag = avtm_pkg::TAG_W'($urandom());
      send_q.push_back(w);
      words_queued++;
   endtask

   task automatic queue_random(input int unsigned count, input int unsigned video_pct,
                               input int unsigned clear_pct);
      packet_type  w;
      int unsigned r;
      repeat (count) begin
         w.op = ($urandom_range(0, 99) < clear_pct) ? avtm_pkg::OP_CLEAR : avtm_pkg::OP_PUSH;
         w.video_kind = $urandom_range(0, 99) < video_pct;
         w.tag = avtm_pkg::TAG_W'($urandom());
         r = $urandom_range(0, 99);
         if (r < 55) begin
            ts_base = ts_base + $urandom_range(0, 40);
            w.timestamp = ts_base - $urandom_range(0, 60);
         end else if (r < 70) begin
            w.timestamp = ts_last;
         end else if (r < 85) begin
            w.timestamp = $urandom();
         end else if (r < 92) begin
            w.timestamp = $urandom_range(0, 3);
         end else begin
            w.timestamp = TIME_MAX - $urandom_range(0, 3);
         end
         ts_last = w.timestamp;
         send_q.push_back(w);
         words_queued++;
      end
   endtask

   // Configuration changes only once every word is taken and the block has gone quiet.
   task automatic wait_drained();
      while (words_taken != words_queued || release_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [avtm_pkg::THR_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= avtm_pkg::CSR_PURE_THRESHOLD_ADDR;
      csr_pwdata <= avtm_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      threshold_copy = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_read_check();
      logic [avtm_pkg::CSR_DATA_W-1:0] seen;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= avtm_pkg::CSR_PURE_THRESHOLD_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      seen = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (seen !== avtm_pkg::CSR_DATA_W'(threshold_copy)) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("threshold readback: expected %0d actual %0d", threshold_copy, seen);
         end
      end
   endtask

   task automatic run_phase(input logic [avtm_pkg::THR_W-1:0] thr, input int unsigned count,
                            input int unsigned video_pct, input int unsigned clear_pct,
                            input bit burst);
      wait_drained();
      csr_write(thr);
      csr_read_check();
      burst_mode = burst;
      queue_random(count, video_pct, clear_pct);
   endtask

   initial begin
      int i;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.op = avtm_pkg::OP_PUSH;
      req_if.timestamp = '0;
      req_if.video_kind = 1'b0;
      req_if.packet_tag = '0;
      rsp_if.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_read_check();
      queue_push('0, 1'b0, '0);
      queue_push(TIME_MAX, 1'b1, '1);
      queue_push(32'd5, 1'b1, 16'h1234);
      queue_push(32'd5, 1'b0, 16'h5555);
      queue_clear();
      queue_push(32'h7FFF_FFFF, 1'b0, 16'hAAAA);

      // A threshold of zero lets every push release the head.
      wait_drained();
      csr_write('0);
      csr_read_check();
      queue_push(32'd100, 1'b1, 16'h0001);
      queue_push(32'd50, 1'b0, 16'h0002);

      // A pure video stream fills the store, then full-queue pushes force releases.
      wait_drained();
      csr_write(7'd127);
      csr_read_check();
      queue_clear();
      for (i = 0; i < DEPTH; i++) begin
         queue_push(32'd1000 - 32'(10 * ((i == 4) ? 3 : i)), 1'b1,
                    avtm_pkg::TAG_W'(16'h0100 + i));
      end
      queue_push(32'd1, 1'b1, 16'h0F0F);
      queue_push(32'd850, 1'b0, 16'hF0F0);

      run_phase(7'd1, 120, 50, 2, 1'b0);
      run_phase(7'd64, 120, 100, 1, 1'b0);
      run_phase(7'd127, 120, 0, 1, 1'b0);
      run_phase(7'd0, 100, 50, 3, 1'b0);
      run_phase(7'd16, 130, 90, 2, 1'b0);
      run_phase(7'd17, 130, 97, 1, 1'b1);
      run_phase(avtm_pkg::THR_W'($urandom_range(1, 64)), 130, 50, 2, 1'b1);
      run_phase(7'd2, 130, 10, 2, 1'b0);
      run_phase(avtm_pkg::PURE_THRESHOLD_RESET, 130, 70, 3, 1'b0);
      run_phase(avtm_pkg::THR_W'($urandom_range(1, 127)), 130, $urandom_range(0, 100), 2,
                1'b0);

      burst_mode = 1'b0;
      wait_drained();
      if (mismatches == 0 && release_due.size() == 0) begin
         $display("[av_timestamp_mix_reorder_queue_core] OK");
      end else begin
         $display("[av_timestamp_mix_reorder_queue_core] ERROR");
      end
      $finish;
   end

endmodule
